FILE: rtl/tcgr_pkg.sv
// shared types and constants of the text cell glyph renderer
// used by tcgr_ctrl, tcgr_dpath and text_cell_glyph_renderer_unit
package tcgr_pkg;

   // font geometry defaults and fixed glyph width
   localparam int GLYPH_HEIGHT      = 16;
   localparam int GLYPH_COUNT       = 256;
   localparam int GLYPH_WIDTH       = 8;
   localparam int PIXELS_PER_RESULT = 4;
   localparam int MAX_RESULTS       = 32;
   localparam int GROUPS            = (GLYPH_WIDTH + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
   localparam int LANES             = 4;

   // field widths
   localparam int COLOR_W    = 24;
   localparam int COLS_W     = 9;
   localparam int PITCH_W    = 13;
   localparam int ADDR_W     = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam int ACTION_W   = 2;
   localparam int CODE_W     = 8;
   localparam int LINE_W     = 4;
   localparam int BITS_W     = 8;
   localparam int RECT_X_W   = 12;
   localparam int RECT_Y_W   = 13;
   localparam int POS_W      = 8;
   localparam int CNT_W      = $clog2(MAX_RESULTS);

   // request actions
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // control characters
   localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CODE_W-1:0] CHAR_RETURN  = 8'h0D;

   // response kinds
   localparam logic KIND_PIXELS = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FORE_COLOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COLOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_BASE = 3'd4;

   // register reset values
   localparam logic [COLOR_W-1:0] FORE_COLOR_RST = 24'h7F7F7F;
   localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 24'h000000;
   localparam logic [COLS_W-1:0]  COLUMNS_RST    = 9'd80;
   localparam logic [PITCH_W-1:0] PITCH_RST      = 13'd640;
   localparam logic [ADDR_W-1:0]  FRAME_BASE_RST = 25'd0;

   // commands from controller to datapath
   typedef struct packed {
      logic font_wr;
      logic rect_clr;
      logic col_home;
      logic newline;
      logic char_start;
      logic mult;
      logic base;
      logic emit;
      logic flush;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

FILE: rtl/tcgr_ctrl.sv
// controller state machine of the text cell glyph renderer
// depends on tcgr_pkg; drives tcgr_dpath through cmd_type and reads status_type
module tcgr_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tcgr_pkg::ACTION_W-1:0]    req_action,
   input  logic [tcgr_pkg::CODE_W-1:0]      req_char_code,
   input  tcgr_pkg::status_type             status,
   output tcgr_pkg::cmd_type                cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_BASE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      rdy_ff, rdy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_action)
                  tcgr_pkg::ACT_LOAD:  cmd.font_wr  = 1'b1;
                  tcgr_pkg::ACT_CLEAR: cmd.rect_clr = 1'b1;
                  tcgr_pkg::ACT_PUT: begin
                     priority if (req_char_code == tcgr_pkg::CHAR_NEWLINE) begin
                        cmd.newline = 1'b1;
                        state_in    = ST_FLUSH;
                     end else if (req_char_code == tcgr_pkg::CHAR_RETURN) begin
                        cmd.col_home = 1'b1;
                     end else begin
                        cmd.char_start = 1'b1;
                        state_in       = ST_MULT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rdy_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rdy_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         rdy_ff   <= rdy_in;
      end
   end

   assign req_tready = rdy_ff;

   a_rdy_matches_idle: assert property (@(posedge clock) disable iff (reset)
      rdy_ff == (state_ff == ST_IDLE))
      else $error("ready out of step with idle state");

   a_char_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.char_start |=> cmd.mult ##1 cmd.base)
      else $error("character setup sequence broken");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !status.out_free) |=> (state_ff == ST_EMIT))
      else $error("left emit while result register was full");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.font_wr, cmd.rect_clr, cmd.col_home, cmd.newline, cmd.char_start,
                cmd.mult, cmd.base, cmd.emit, cmd.flush}))
      else $error("more than one command at once");

endmodule

FILE: rtl/tcgr_dpath.sv
// datapath of the text cell glyph renderer: registers, cursor, dirty rectangle,
// font store and result register; depends on tcgr_pkg, commanded by tcgr_ctrl
module tcgr_dpath #(
   parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT,
   parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [tcgr_pkg::CODE_W-1:0]            req_char_code,
   input  logic [tcgr_pkg::LINE_W-1:0]            req_glyph_line,
   input  logic [tcgr_pkg::BITS_W-1:0]            req_glyph_bits,
   input  tcgr_pkg::cmd_type                      cmd,
   output tcgr_pkg::status_type                   status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic                                   rsp_kind,
   output logic [tcgr_pkg::ADDR_W-1:0]            rsp_pixel_address,
   output logic [tcgr_pkg::LANES-1:0][tcgr_pkg::COLOR_W-1:0] rsp_colors,
   output logic                                   rsp_last_of_run,
   output logic [tcgr_pkg::RECT_X_W-1:0]          rsp_dirty_min_x,
   output logic [tcgr_pkg::RECT_Y_W-1:0]          rsp_dirty_min_y,
   output logic [tcgr_pkg::RECT_X_W-1:0]          rsp_dirty_max_x,
   output logic [tcgr_pkg::RECT_Y_W-1:0]          rsp_dirty_max_y
);

   localparam int ADDR_W     = tcgr_pkg::ADDR_W;
   localparam int COLOR_W    = tcgr_pkg::COLOR_W;
   localparam int RX_W       = tcgr_pkg::RECT_X_W;
   localparam int PPR        = tcgr_pkg::PIXELS_PER_RESULT;
   localparam int GROUPS     = tcgr_pkg::GROUPS;
   localparam int K_W        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int LN_W       = $clog2(GLYPH_HEIGHT);
   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int FA_W       = $clog2(FONT_DEPTH);
   localparam int CIDX_W     = $clog2(GLYPH_COUNT);
   localparam int Y0_W       = $clog2(256 * GLYPH_HEIGHT);
   localparam int RY_W       = (Y0_W + 1 > tcgr_pkg::RECT_Y_W) ? Y0_W + 1 : tcgr_pkg::RECT_Y_W;
   localparam int X0_W       = tcgr_pkg::POS_W + 3;
   localparam int PROD_W     = Y0_W + tcgr_pkg::PITCH_W;
   localparam int CNT_W      = tcgr_pkg::CNT_W;
   localparam int NRES       = (GLYPH_HEIGHT * GROUPS < tcgr_pkg::MAX_RESULTS) ?
                               GLYPH_HEIGHT * GROUPS : tcgr_pkg::MAX_RESULTS;

   // configuration
   logic [COLOR_W-1:0]            fore_ff, back_ff;
   logic [tcgr_pkg::COLS_W-1:0]   cols_ff;
   logic [tcgr_pkg::PITCH_W-1:0]  pitch_ff;
   logic [ADDR_W-1:0]             base_ff;

   // cursor and dirty rectangle
   logic [tcgr_pkg::POS_W-1:0]    col_ff, row_ff;
   logic signed [RX_W-1:0]        min_x_ff, max_x_ff;
   logic signed [RY_W-1:0]        min_y_ff, max_y_ff;

   // per character working state
   logic [X0_W-1:0]               x0_ff;
   logic [Y0_W-1:0]               y0_ff;
   logic [FA_W-1:0]               glyph_base_ff;
   logic                          code_ok_ff;
   logic [ADDR_W-1:0]             prod_ff, line_addr_ff;
   logic [LN_W-1:0]               ln_ff;
   logic [K_W-1:0]                k_ff;
   logic [CNT_W-1:0]              cnt_ff;

   // font store
   logic [7:0]                    font_mem [FONT_DEPTH];
   logic [7:0]                    font_q_ff;
   logic [FA_W-1:0]               rd_addr, wr_addr;
   logic                          wr_ok;
   logic [LN_W-1:0]               ln_next;

   // result register
   logic                          out_valid_ff, out_kind_ff, out_last_ff;
   logic [ADDR_W-1:0]             out_addr_ff;
   logic [tcgr_pkg::LANES-1:0][COLOR_W-1:0] out_colors_ff;
   logic [RX_W-1:0]               out_min_x_ff, out_max_x_ff;
   logic [tcgr_pkg::RECT_Y_W-1:0] out_min_y_ff, out_max_y_ff;

   logic [tcgr_pkg::COLS_W-1:0]   cols_eff;
   logic                          wrap;
   logic                          k_last;
   logic                          out_load;
   logic [PROD_W-1:0]             prod_full;
   logic signed [RX_W-1:0]        x_lo, x_hi;
   logic signed [RY_W-1:0]        y_lo, y_hi;
   logic [7:0]                    glyph, glyph_rev;
   logic [tcgr_pkg::LANES-1:0][COLOR_W-1:0] pix_colors;
   logic [ADDR_W-1:0]             group_addr;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fore_ff  <= tcgr_pkg::FORE_COLOR_RST;
         back_ff  <= tcgr_pkg::BACK_COLOR_RST;
         cols_ff  <= tcgr_pkg::COLUMNS_RST;
         pitch_ff <= tcgr_pkg::PITCH_RST;
         base_ff  <= tcgr_pkg::FRAME_BASE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcgr_pkg::REG_FORE_COLOR: fore_ff  <= csr_wdata[COLOR_W-1:0];
            tcgr_pkg::REG_BACK_COLOR: back_ff  <= csr_wdata[COLOR_W-1:0];
            tcgr_pkg::REG_COLUMNS:    cols_ff  <= csr_wdata[tcgr_pkg::COLS_W-1:0];
            tcgr_pkg::REG_PITCH:      pitch_ff <= csr_wdata[tcgr_pkg::PITCH_W-1:0];
            tcgr_pkg::REG_FRAME_BASE: base_ff  <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // column count clamped to 1..256
   always_comb begin
      priority if (cols_ff == '0) begin
         cols_eff = tcgr_pkg::COLS_W'(1);
      end else if (cols_ff > tcgr_pkg::COLS_W'(256)) begin
         cols_eff = tcgr_pkg::COLS_W'(256);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign wrap = ({1'b0, col_ff} + tcgr_pkg::COLS_W'(1)) >= cols_eff;

   // cell corners in signed rectangle coordinates
   assign x_lo = $signed({1'b0, x0_ff});
   assign x_hi = $signed({1'b0, x0_ff} + RX_W'(tcgr_pkg::GLYPH_WIDTH - 1));
   assign y_lo = $signed(RY_W'(y0_ff));
   assign y_hi = $signed(RY_W'(y0_ff) + RY_W'(GLYPH_HEIGHT - 1));

   // cursor and dirty rectangle
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         min_x_ff <= '1;
         min_y_ff <= '1;
         max_x_ff <= '1;
         max_y_ff <= '1;
      end else begin
         if (cmd.rect_clr) begin
            min_x_ff <= '1;
            min_y_ff <= '1;
            max_x_ff <= '1;
            max_y_ff <= '1;
         end
         if (cmd.col_home) begin
            col_ff <= '0;
         end
         if (cmd.newline || (cmd.char_start && wrap)) begin
            col_ff <= '0;
            if (row_ff != '1) begin
               row_ff <= row_ff + tcgr_pkg::POS_W'(1);
            end
         end else if (cmd.char_start) begin
            col_ff <= col_ff + tcgr_pkg::POS_W'(1);
         end
         if (cmd.mult) begin
            if (min_x_ff < 0 || x_lo < min_x_ff) min_x_ff <= x_lo;
            if (min_y_ff < 0 || y_lo < min_y_ff) min_y_ff <= y_lo;
            if (x_hi > max_x_ff) max_x_ff <= x_hi;
            if (y_hi > max_y_ff) max_y_ff <= y_hi;
         end
      end
   end

   assign prod_full = y0_ff * pitch_ff;
   assign k_last    = (k_ff == K_W'(GROUPS - 1));

   // character setup and group walk
   always_ff @(posedge clock) begin
      if (cmd.char_start) begin
         x0_ff         <= {col_ff, 3'b000};
         y0_ff         <= Y0_W'(row_ff * GLYPH_HEIGHT);
         glyph_base_ff <= FA_W'(req_char_code[CIDX_W-1:0] * GLYPH_HEIGHT);
         code_ok_ff    <= int'(req_char_code) < GLYPH_COUNT;
      end
      if (cmd.mult) begin
         prod_ff <= ADDR_W'(prod_full);
      end
      if (cmd.base) begin
         line_addr_ff <= base_ff + prod_ff + ADDR_W'(x0_ff);
         ln_ff        <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (k_last) begin
            k_ff         <= '0;
            ln_ff        <= ln_ff + LN_W'(1);
            line_addr_ff <= line_addr_ff + ADDR_W'(pitch_ff);
         end else begin
            k_ff <= k_ff + K_W'(1);
         end
      end
   end

   // font store: read ahead so the byte of the shown line is always in font_q_ff
   always_comb begin
      priority if (cmd.base) begin
         ln_next = '0;
      end else if (cmd.emit && k_last) begin
         ln_next = ln_ff + LN_W'(1);
      end else begin
         ln_next = ln_ff;
      end
   end

   assign rd_addr = glyph_base_ff + FA_W'(ln_next);
   assign wr_addr = FA_W'(req_char_code[CIDX_W-1:0] * GLYPH_HEIGHT) + FA_W'(req_glyph_line);
   assign wr_ok   = (int'(req_char_code) < GLYPH_COUNT) &&
                    (int'(req_glyph_line) < GLYPH_HEIGHT);

   always_ff @(posedge clock) begin
      if (cmd.font_wr && wr_ok) begin
         font_mem[wr_addr] <= req_glyph_bits;
      end
      font_q_ff <= font_mem[rd_addr];
   end

   // pixel colors of the current group
   assign glyph = code_ok_ff ? font_q_ff : 8'h00;

   always_comb begin : color_sel
      logic [3:0] px;
      for (int i = 0; i < 8; i++) begin
         glyph_rev[i] = glyph[7 - i];
      end
      for (int j = 0; j < tcgr_pkg::LANES; j++) begin
         px = 4'(k_ff * PPR + j);
         if (j < PPR && px < 4'd8) begin
            pix_colors[j] = glyph_rev[px[2:0]] ? fore_ff : back_ff;
         end else begin
            pix_colors[j] = '0;
         end
      end
   end

   assign group_addr = line_addr_ff + ADDR_W'(k_ff * PPR);

   // result register
   assign out_load = cmd.emit || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= cmd.flush ? tcgr_pkg::KIND_FLUSH : tcgr_pkg::KIND_PIXELS;
         out_addr_ff   <= cmd.flush ? '0 : group_addr;
         out_colors_ff <= cmd.flush ? '0 : pix_colors;
         out_last_ff   <= cmd.flush || status.emit_last;
         out_min_x_ff  <= min_x_ff;
         out_max_x_ff  <= max_x_ff;
         out_min_y_ff  <= min_y_ff[tcgr_pkg::RECT_Y_W-1:0];
         out_max_y_ff  <= max_y_ff[tcgr_pkg::RECT_Y_W-1:0];
      end
   end

   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.emit_last = (cnt_ff == CNT_W'(NRES - 1));

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_colors        = out_colors_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_dirty_min_x   = out_min_x_ff;
   assign rsp_dirty_min_y   = out_min_y_ff;
   assign rsp_dirty_max_x   = out_max_x_ff;
   assign rsp_dirty_max_y   = out_max_y_ff;

endmodule

FILE: rtl/text_cell_glyph_renderer_unit.sv
// top level of the text cell glyph renderer
// depends on tcgr_pkg, tcgr_ctrl and tcgr_dpath
//
// An 8-pixel-wide bitmap font text console. Font rows are loaded one byte per
// request; each printable character request is drawn at the text cursor as
// GLYPH_HEIGHT rows of 8 pixels and leaves as pixel writes of four pixels each,
// 32 responses per character with the default geometry, the final one marked
// with tlast. Every response also carries the dirty rectangle after that
// request (-1 in all four fields when empty). A newline moves the cursor to the
// start of the next row and gives one flush response; carriage return homes the
// column; the row stops at 255. A font load, a rectangle clear or a carriage
// return is handled in the cycle it is taken; a newline then waits in the
// flush state for a free response register; a printable character first goes
// through setup (cursor and cell origin, the row times pitch multiply, the
// line start address) and then gives one response per cycle for as long as
// the response side keeps taking them. That pace is set by the single read
// port of the font store, which gives one glyph row per line, and by the one
// response register. A new request is taken as soon as the last response of
// the previous one sits in the response register. The font store needs no
// clearing after reset; a glyph row never loaded gives undefined colors.
module text_cell_glyph_renderer_unit #(
   parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT,
   parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,  // char_code, glyph_line, glyph_bits, pad
   input  logic [tcgr_pkg::ACTION_W-1:0]      req_tuser,  // action
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [175:0]                       rsp_tdata,  // pixel_address, color_a, color_b,
                                                          // color_c, color_d, dirty_min_x,
                                                          // dirty_min_y, dirty_max_x,
                                                          // dirty_max_y, pad
   output logic                               rsp_tuser,  // kind
   output logic                               rsp_tlast   // last_of_run
);

   tcgr_pkg::cmd_type    cmd;
   tcgr_pkg::status_type status;

   // request fields
   logic [tcgr_pkg::CODE_W-1:0]  req_char_code;
   logic [tcgr_pkg::LINE_W-1:0]  req_glyph_line;
   logic [tcgr_pkg::BITS_W-1:0]  req_glyph_bits;

   // response fields
   logic [tcgr_pkg::ADDR_W-1:0]  rsp_pixel_address;
   logic [tcgr_pkg::LANES-1:0][tcgr_pkg::COLOR_W-1:0] rsp_colors;
   logic [tcgr_pkg::RECT_X_W-1:0] rsp_dirty_min_x, rsp_dirty_max_x;
   logic [tcgr_pkg::RECT_Y_W-1:0] rsp_dirty_min_y, rsp_dirty_max_y;

   assign req_char_code  = req_tdata[7:0];
   assign req_glyph_line = req_tdata[11:8];
   assign req_glyph_bits = req_tdata[19:12];

   // sequencing of each request
   tcgr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tuser),
      .req_char_code (req_char_code),
      .status        (status),
      .cmd           (cmd)
   );

   // registers, cursor, rectangle, font store and response register
   tcgr_dpath #(
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_char_code     (req_char_code),
      .req_glyph_line    (req_glyph_line),
      .req_glyph_bits    (req_glyph_bits),
      .cmd               (cmd),
      .status            (status),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_kind          (rsp_tuser),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_colors        (rsp_colors),
      .rsp_last_of_run   (rsp_tlast),
      .rsp_dirty_min_x   (rsp_dirty_min_x),
      .rsp_dirty_min_y   (rsp_dirty_min_y),
      .rsp_dirty_max_x   (rsp_dirty_max_x),
      .rsp_dirty_max_y   (rsp_dirty_max_y)
   );

   // response packing, lowest field first
   assign rsp_tdata = {5'b00000,
                       rsp_dirty_max_y,
                       rsp_dirty_max_x,
                       rsp_dirty_min_y,
                       rsp_dirty_min_x,
                       rsp_colors[3],
                       rsp_colors[2],
                       rsp_colors[1],
                       rsp_colors[0],
                       rsp_pixel_address};

endmodule
